/* rtl/hiit_pkg.sv */
// Shared constants, codes and command/status types of the identity interning table.
package hiit_pkg;

   // Sizes of the index and the record store.
   localparam int INDEX_ENTRIES = 1024;
   localparam int MAX_RECORDS   = 512;
   localparam int IDX_W         = $clog2(INDEX_ENTRIES);
   localparam int REC_AW        = $clog2(MAX_RECORDS);
   localparam int CNT_W         = $clog2(MAX_RECORDS + 1);

   // Field widths.
   localparam int SLOT_W   = 10;
   localparam int KIND_W   = 4;
   localparam int NAME_W   = 32;
   localparam int FP_W     = 32;
   localparam int REC_W    = NAME_W + SLOT_W + KIND_W;
   localparam int HASH_W   = 64;
   localparam int HALF_W   = HASH_W / 2;
   localparam int PAD_W    = HASH_W - NAME_W - SLOT_W - KIND_W;

   // Hash constants.
   localparam logic [HASH_W-1:0] MIX_A    = 64'hbf58476d1ce4e5b9;
   localparam logic [HASH_W-1:0] MIX_B    = 64'h94d049bb133111eb;
   localparam logic [HASH_W-1:0] KIND_MUL = 64'h9e3779b97f4a7c15;

   // Special slots and kinds.
   localparam logic [SLOT_W-1:0] NO_SLOT     = SLOT_W'(0);
   localparam logic [SLOT_W-1:0] ROOT_SLOT   = SLOT_W'(1);
   localparam logic [SLOT_W-1:0] FIRST_LOCAL = SLOT_W'(2);
   localparam logic [KIND_W-1:0] ROOT_KIND   = KIND_W'(0);

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_INVALID   = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      MUL_LO   = 2'd0,
      MUL_HI_A = 2'd1,
      MUL_HI_B = 2'd2
   } mul_phase_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_MA0,
      S_MA1,
      S_MA2,
      S_MID,
      S_MB0,
      S_MB1,
      S_MB2,
      S_HASH,
      S_CHECK,
      S_PROBE_RD,
      S_PROBE_CHK,
      S_REC_CHK,
      S_MISS,
      S_RESP
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic          accept;
      logic          mul_en;
      mul_phase_type mul_phase;
      logic          mul_sel_b;
      logic          load_mid;
      logic          load_hash;
      logic          probe_rd;
      logic          rec_rd;
      logic          advance;
      logic          note_free;
      logic          set_hit;
      logic          insert;
      logic          clr_step;
      logic          rsp_load;
      status_type    rsp_status;
   } hiit_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic clr_last;
      logic req_invalid;
      logic op_resolve;
      logic slot_empty;
      logic fp_cand;
      logic rec_match;
      logic probes_last;
      logic store_full;
      logic have_free;
      logic out_free;
   } hiit_sts_type;

endpackage

/* rtl/hiit_req_if.sv */
// Request channel: valid/ready handshake carrying one lookup word.
interface hiit_req_if;
   import hiit_pkg::*;

   logic              valid;
   logic              ready;
   logic              kind;
   logic [SLOT_W-1:0] parent_slot;
   logic [KIND_W-1:0] parent_kind;
   logic [NAME_W-1:0] name_id;
   logic [KIND_W-1:0] entry_kind;

   modport source (output valid, kind, parent_slot, parent_kind, name_id, entry_kind,
                   input ready);
   modport sink   (input valid, kind, parent_slot, parent_kind, name_id, entry_kind,
                   output ready);
endinterface

/* rtl/hiit_rsp_if.sv */
// Response channel: valid/ready handshake carrying one result word.
interface hiit_rsp_if;
   import hiit_pkg::*;

   logic              valid;
   logic              ready;
   logic [1:0]        status;
   logic [SLOT_W-1:0] result_slot;
   logic [KIND_W-1:0] result_kind;
   logic              is_new;

   modport source (output valid, status, result_slot, result_kind, is_new, input ready);
   modport sink   (input valid, status, result_slot, result_kind, is_new, output ready);
endinterface

/* rtl/hashed_identity_interning_table.sv */
// Once the request word is taken, the hash is built on one shared 32x32 multiplier, the
// request is checked, each probe reads and checks an index entry, a fingerprint candidate
// adds a record compare and a miss adds a step. Throughput: one request at a time; the next
// word is taken in the cycle after the response register loads. A stalled response waits.
// Reset (synchronous): after reset the 1024-entry index is cleared one entry per cycle,
// so no request is taken for 1024 cycles; the name count register resets to 1.
module hashed_identity_interning_table (
   input  logic                        clock,
   input  logic                        reset,
   hiit_req_if.sink                    req_bus,
   hiit_rsp_if.source                  rsp_bus,
   input  logic                        csr_wr_en,
   input  logic [hiit_pkg::NAME_W-1:0] csr_wr_data
);
   import hiit_pkg::*;

   hiit_cmd_type cmd;
   hiit_sts_type sts;

   hiit_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   hiit_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .in_op           (req_bus.kind),
      .in_parent_slot  (req_bus.parent_slot),
      .in_parent_kind  (req_bus.parent_kind),
      .in_name_id      (req_bus.name_id),
      .in_entry_kind   (req_bus.entry_kind),
      .rsp_ready       (rsp_bus.ready),
      .rsp_valid       (rsp_bus.valid),
      .rsp_status      (rsp_bus.status),
      .rsp_result_slot (rsp_bus.result_slot),
      .rsp_result_kind (rsp_bus.result_kind),
      .rsp_is_new      (rsp_bus.is_new)
   );

`ifndef SYNTHESIS
   // A created record is always reported as a success.
   a_new_is_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.is_new |-> rsp_bus.status == ST_OK)
      else $error("new record reported with a failing status");

   // A failing word carries no slot.
   a_fail_no_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.status != ST_OK |-> rsp_bus.result_slot == NO_SLOT)
      else $error("failing word carries a slot");

   // Insertion only with room in the store and a free index entry.
   a_insert_room: assert property (@(posedge clock) disable iff (reset)
      cmd.insert |-> !sts.store_full && sts.have_free)
      else $error("insert without room");

   // The response register is loaded only when it is free.
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> sts.out_free)
      else $error("response overwritten");
`endif

endmodule

/* rtl/hiit_datapath.sv */
// Datapath: hash unit, probe index memory, record memory and response register.
module hiit_datapath (
   input  logic                      clock,
   input  logic                      reset,
   input  hiit_pkg::hiit_cmd_type    cmd,
   output hiit_pkg::hiit_sts_type    sts,
   input  logic                      csr_wr_en,
   input  logic [hiit_pkg::NAME_W-1:0] csr_wr_data,
   input  logic                      in_op,
   input  logic [hiit_pkg::SLOT_W-1:0] in_parent_slot,
   input  logic [hiit_pkg::KIND_W-1:0] in_parent_kind,
   input  logic [hiit_pkg::NAME_W-1:0] in_name_id,
   input  logic [hiit_pkg::KIND_W-1:0] in_entry_kind,
   input  logic                      rsp_ready,
   output logic                      rsp_valid,
   output logic [1:0]                rsp_status,
   output logic [hiit_pkg::SLOT_W-1:0] rsp_result_slot,
   output logic [hiit_pkg::KIND_W-1:0] rsp_result_kind,
   output logic                      rsp_is_new
);
   import hiit_pkg::*;

   // Configuration and latched request.
   logic [NAME_W-1:0] name_count_ff;
   logic              op_ff;
   logic [SLOT_W-1:0] pslot_ff;
   logic [KIND_W-1:0] pkind_ff;
   logic [NAME_W-1:0] name_ff;
   logic [KIND_W-1:0] ekind_ff;

   // Hash unit.
   logic [HASH_W-1:0] m_ff, m_in;
   logic [HASH_W-1:0] acc_ff, acc_in;
   logic [HASH_W-1:0] v_word, kind_prod, x_word, mid_word, h_word, mul_const;
   logic [HALF_W-1:0] mul_a, mul_b, fold;
   logic [HASH_W-1:0] mul_p;

   // Probe walk.
   logic [IDX_W-1:0]  pos_ff;
   logic [FP_W-1:0]   fp_ff;
   logic [IDX_W-1:0]  probe_cnt_ff;
   logic              have_free_ff;
   logic [CNT_W-1:0]  count_ff;
   logic [IDX_W-1:0]  clr_ff;
   logic [SLOT_W-1:0] res_slot_ff;
   logic              res_new_ff;

   // Memories and their read registers.
   logic [FP_W+SLOT_W-1:0]  probe_mem_ff [INDEX_ENTRIES];
   logic [FP_W+SLOT_W-1:0]  probe_rd_ff;
   logic [KIND_W+REC_W-1:0] rec_mem_ff [MAX_RECORDS];
   logic [KIND_W+REC_W-1:0] rec_rd_ff;

   logic                    probe_we;
   logic [IDX_W-1:0]        probe_wa;
   logic [FP_W+SLOT_W-1:0]  probe_wd;
   logic [REC_AW-1:0]       rec_ra;
   logic [KIND_W+REC_W-1:0] key_rec;

   // Response register.
   logic              rsp_valid_ff;
   status_type        rsp_status_ff;
   logic [SLOT_W-1:0] rsp_slot_ff;
   logic [KIND_W-1:0] rsp_kind_ff;
   logic              rsp_new_ff;

   // Decoded probe word and checks.
   logic [SLOT_W-1:0] p_slot, p_idx, par_idx, new_slot;
   logic [FP_W-1:0]   p_fp;
   logic              parent_ok;

   // Input hashing: pack the key, mix in the kind and apply the first xor-shift.
   always_comb begin
      v_word    = {in_name_id, PAD_W'(0), in_parent_slot, in_parent_kind};
      kind_prod = KIND_MUL * {{(HASH_W-KIND_W){1'b0}}, in_entry_kind};
      x_word    = v_word ^ kind_prod;
      mid_word  = acc_ff ^ (acc_ff >> 27);
      if (cmd.accept) begin
         m_in = x_word ^ (x_word >> 30);
      end else if (cmd.load_mid) begin
         m_in = mid_word;
      end else begin
         m_in = m_ff;
      end
   end

   // One 32x32 multiplier builds the low 64 bits of a 64x64 product in three steps.
   always_comb begin
      mul_const = cmd.mul_sel_b ? MIX_B : MIX_A;
      unique case (cmd.mul_phase)
         MUL_HI_A: begin
            mul_a = m_ff[HASH_W-1:HALF_W];
            mul_b = mul_const[HALF_W-1:0];
         end
         MUL_HI_B: begin
            mul_a = m_ff[HALF_W-1:0];
            mul_b = mul_const[HASH_W-1:HALF_W];
         end
         default: begin
            mul_a = m_ff[HALF_W-1:0];
            mul_b = mul_const[HALF_W-1:0];
         end
      endcase
      mul_p = {{HALF_W{1'b0}}, mul_a} * {{HALF_W{1'b0}}, mul_b};
      if (!cmd.mul_en) begin
         acc_in = acc_ff;
      end else if (cmd.mul_phase == MUL_LO) begin
         acc_in = mul_p;
      end else begin
         acc_in = {acc_ff[HASH_W-1:HALF_W] + mul_p[HALF_W-1:0], acc_ff[HALF_W-1:0]};
      end
   end

   // Final xor-shift and fingerprint fold.
   always_comb begin
      h_word = acc_ff ^ (acc_ff >> 31);
      fold   = h_word[HALF_W-1:0] ^ h_word[HASH_W-1:HALF_W];
   end

   // Decode the probe word and the parent check.
   always_comb begin
      p_slot   = probe_rd_ff[SLOT_W-1:0];
      p_fp     = probe_rd_ff[FP_W+SLOT_W-1:SLOT_W];
      p_idx    = p_slot - FIRST_LOCAL;
      par_idx  = pslot_ff - FIRST_LOCAL;
      new_slot = SLOT_W'(count_ff) + FIRST_LOCAL;
      key_rec  = {ekind_ff, name_ff, pslot_ff, pkind_ff};
      if (pslot_ff == NO_SLOT) begin
         parent_ok = 1'b0;
      end else if (pslot_ff == ROOT_SLOT) begin
         parent_ok = (pkind_ff == ROOT_KIND);
      end else begin
         parent_ok = (par_idx < SLOT_W'(count_ff)) &&
                     (rec_rd_ff[KIND_W+REC_W-1:REC_W] == pkind_ff);
      end
   end

   // Status toward the controller.
   always_comb begin
      sts.clr_last    = &clr_ff;
      sts.req_invalid = !parent_ok || (name_ff == '0) || (name_ff >= name_count_ff) ||
                        (ekind_ff == ROOT_KIND);
      sts.op_resolve  = op_ff;
      sts.slot_empty  = (p_slot == NO_SLOT);
      sts.fp_cand     = (p_slot >= FIRST_LOCAL) && (p_fp == fp_ff) &&
                        (p_idx < SLOT_W'(count_ff));
      sts.rec_match   = (rec_rd_ff == key_rec);
      sts.probes_last = &probe_cnt_ff;
      sts.store_full  = (count_ff >= CNT_W'(MAX_RECORDS));
      sts.have_free   = have_free_ff;
      sts.out_free    = !rsp_valid_ff || rsp_ready;
   end

   // Probe index write port: clearing sweep or insertion.
   always_comb begin
      probe_we = cmd.clr_step || cmd.insert;
      probe_wa = cmd.clr_step ? clr_ff : pos_ff;
      probe_wd = cmd.clr_step ? '0 : {fp_ff, new_slot};
      rec_ra   = cmd.accept ? REC_AW'(in_parent_slot - FIRST_LOCAL) : REC_AW'(p_idx);
   end

   // Probe index memory.
   always_ff @(posedge clock) begin
      if (probe_we) begin
         probe_mem_ff[probe_wa] <= probe_wd;
      end
      if (cmd.probe_rd) begin
         probe_rd_ff <= probe_mem_ff[pos_ff];
      end
   end

   // Record memory: kind and packed key of each local slot.
   always_ff @(posedge clock) begin
      if (cmd.insert) begin
         rec_mem_ff[count_ff[REC_AW-1:0]] <= key_rec;
      end
      if (cmd.accept || cmd.rec_rd) begin
         rec_rd_ff <= rec_mem_ff[rec_ra];
      end
   end

   // Payload registers of the hash unit and the request.
   always_ff @(posedge clock) begin
      m_ff   <= m_in;
      acc_ff <= acc_in;
      if (cmd.accept) begin
         op_ff    <= in_op;
         pslot_ff <= in_parent_slot;
         pkind_ff <= in_parent_kind;
         name_ff  <= in_name_id;
         ekind_ff <= in_entry_kind;
      end
      if (cmd.load_hash) begin
         pos_ff <= h_word[IDX_W-1:0];
         fp_ff  <= (fold == '0) ? FP_W'(1) : fold;
      end else if (cmd.advance) begin
         pos_ff <= pos_ff + IDX_W'(1);
      end
      if (cmd.set_hit) begin
         res_slot_ff <= p_slot;
      end else if (cmd.insert) begin
         res_slot_ff <= new_slot;
      end
      if (cmd.rsp_load) begin
         rsp_status_ff <= cmd.rsp_status;
         rsp_slot_ff   <= (cmd.rsp_status == ST_OK) ? res_slot_ff : NO_SLOT;
         rsp_kind_ff   <= (cmd.rsp_status == ST_OK) ? ekind_ff : ROOT_KIND;
         rsp_new_ff    <= (cmd.rsp_status == ST_OK) && res_new_ff;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         name_count_ff <= NAME_W'(1);
         count_ff      <= '0;
         clr_ff        <= '0;
         probe_cnt_ff  <= '0;
         have_free_ff  <= 1'b0;
         res_new_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            name_count_ff <= csr_wr_data;
         end
         if (cmd.clr_step) begin
            clr_ff <= clr_ff + IDX_W'(1);
         end
         if (cmd.load_hash) begin
            probe_cnt_ff <= '0;
            have_free_ff <= 1'b0;
         end else begin
            if (cmd.advance) begin
               probe_cnt_ff <= probe_cnt_ff + IDX_W'(1);
            end
            if (cmd.note_free) begin
               have_free_ff <= 1'b1;
            end
         end
         if (cmd.insert) begin
            count_ff   <= count_ff + CNT_W'(1);
            res_new_ff <= 1'b1;
         end else if (cmd.set_hit) begin
            res_new_ff <= 1'b0;
         end
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_result_slot = rsp_slot_ff;
   assign rsp_result_kind = rsp_kind_ff;
   assign rsp_is_new      = rsp_new_ff;

endmodule

/* rtl/hiit_ctrl.sv */
// Controller: sequences clearing, hashing, the probe walk, insertion and the response.
module hiit_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  hiit_pkg::hiit_sts_type sts,
   output hiit_pkg::hiit_cmd_type cmd
);
   import hiit_pkg::*;

   state_type  state_ff, state_in;
   status_type res_status_ff, res_status_in;

   // Next state and the status of the word being built.
   always_comb begin
      state_in      = state_ff;
      res_status_in = res_status_ff;
      unique case (state_ff)
         S_CLEAR: begin
            if (sts.clr_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) state_in = S_MA0;
         end
         S_MA0:  state_in = S_MA1;
         S_MA1:  state_in = S_MA2;
         S_MA2:  state_in = S_MID;
         S_MID:  state_in = S_MB0;
         S_MB0:  state_in = S_MB1;
         S_MB1:  state_in = S_MB2;
         S_MB2:  state_in = S_HASH;
         S_HASH: state_in = S_CHECK;
         S_CHECK: begin
            if (sts.req_invalid) begin
               res_status_in = ST_INVALID;
               state_in      = S_RESP;
            end else begin
               state_in = S_PROBE_RD;
            end
         end
         S_PROBE_RD: state_in = S_PROBE_CHK;
         S_PROBE_CHK: begin
            priority if (sts.slot_empty) begin
               state_in = S_MISS;
            end else if (sts.fp_cand) begin
               state_in = S_REC_CHK;
            end else if (sts.probes_last) begin
               state_in = S_MISS;
            end else begin
               state_in = S_PROBE_RD;
            end
         end
         S_REC_CHK: begin
            priority if (sts.rec_match) begin
               res_status_in = ST_OK;
               state_in      = S_RESP;
            end else if (sts.probes_last) begin
               state_in = S_MISS;
            end else begin
               state_in = S_PROBE_RD;
            end
         end
         S_MISS: begin
            priority if (!sts.op_resolve) begin
               res_status_in = ST_NOT_FOUND;
            end else if (sts.store_full || !sts.have_free) begin
               res_status_in = ST_FULL;
            end else begin
               res_status_in = ST_OK;
            end
            state_in = S_RESP;
         end
         S_RESP: begin
            if (sts.out_free) state_in = S_IDLE;
         end
      endcase
   end

   // Commands for the current state.
   always_comb begin
      cmd            = '0;
      cmd.mul_phase  = MUL_LO;
      cmd.rsp_status = res_status_ff;
      req_ready      = 1'b0;
      unique case (state_ff)
         S_CLEAR: cmd.clr_step = 1'b1;
         S_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
         end
         S_MA0: cmd.mul_en = 1'b1;
         S_MA1: begin
            cmd.mul_en    = 1'b1;
            cmd.mul_phase = MUL_HI_A;
         end
         S_MA2: begin
            cmd.mul_en    = 1'b1;
            cmd.mul_phase = MUL_HI_B;
         end
         S_MID: cmd.load_mid = 1'b1;
         S_MB0: begin
            cmd.mul_en    = 1'b1;
            cmd.mul_sel_b = 1'b1;
         end
         S_MB1: begin
            cmd.mul_en    = 1'b1;
            cmd.mul_sel_b = 1'b1;
            cmd.mul_phase = MUL_HI_A;
         end
         S_MB2: begin
            cmd.mul_en    = 1'b1;
            cmd.mul_sel_b = 1'b1;
            cmd.mul_phase = MUL_HI_B;
         end
         S_HASH:     cmd.load_hash = 1'b1;
         S_CHECK:    ;
         S_PROBE_RD: cmd.probe_rd = 1'b1;
         S_PROBE_CHK: begin
            priority if (sts.slot_empty) begin
               cmd.note_free = 1'b1;
            end else if (sts.fp_cand) begin
               cmd.rec_rd = 1'b1;
            end else begin
               cmd.advance = 1'b1;
            end
         end
         S_REC_CHK: begin
            if (sts.rec_match) begin
               cmd.set_hit = 1'b1;
            end else begin
               cmd.advance = 1'b1;
            end
         end
         S_MISS: begin
            cmd.insert = sts.op_resolve && !sts.store_full && sts.have_free;
         end
         S_RESP: cmd.rsp_load = sts.out_free;
      endcase
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         res_status_ff <= ST_OK;
      end else begin
         state_ff      <= state_in;
         res_status_ff <= res_status_in;
      end
   end

endmodule

/* sim/tb_hashed_identity_interning_table.sv */
// Testbench for the identity interning table: random and directed lookups checked against a predictor.
`timescale 1ns / 100ps

module tb_hashed_identity_interning_table;
   import hiit_pkg::*;

   localparam int WATCHDOG_LIMIT = 40000;

   // Fields of one response word.
   typedef struct {
      status_type        status;
      logic [SLOT_W-1:0] slot;
      logic [KIND_W-1:0] kind;
      logic              is_new;
   } answer_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic [NAME_W-1:0] csr_wr_data = '0;

   hiit_req_if req_bus ();
   hiit_rsp_if rsp_bus ();

   hashed_identity_interning_table dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus.sink),
      .rsp_bus     (rsp_bus.source),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #6 clock = ~clock;

   // Predictor state.
   logic [FP_W-1:0]   index_fp [INDEX_ENTRIES];
   logic [SLOT_W-1:0] index_slot [INDEX_ENTRIES];
   logic [REC_W-1:0]  stored_key [MAX_RECORDS];
   logic [KIND_W-1:0] stored_kind [MAX_RECORDS];
   int unsigned       live_records;
   logic [NAME_W-1:0] name_limit;

   answer_type pending_answers[$];
   int mismatch_count = 0;
   int idle_cycles = 0;
   int rsp_stall_phase = 0;

   // SplitMix64 finalizer.
   function automatic logic [HASH_W-1:0] mix_key(input logic [HASH_W-1:0] v);
      logic [HASH_W-1:0] x;
      x = v ^ (v >> 30);
      x = x * MIX_A;
      x = x ^ (x >> 27);
      x = x * MIX_B;
      return x ^ (x >> 31);
   endfunction

   function automatic bit parent_ok(input logic [SLOT_W-1:0] s, input logic [KIND_W-1:0] k);
      if (s == NO_SLOT) return 1'b0;
      if (s == ROOT_SLOT) return k == ROOT_KIND;
      return (s - 2) < live_records && stored_kind[s-2] == k;
   endfunction

   // Works out the answer to one request and updates the predicted table.
   function automatic answer_type intern_lookup(input logic op, input logic [SLOT_W-1:0] ps,
         input logic [KIND_W-1:0] pk, input logic [NAME_W-1:0] nm,
         input logic [KIND_W-1:0] ek);
      answer_type a;
      logic [13:0] packed_parent;
      logic [REC_W-1:0] key;
      logic [HASH_W-1:0] h;
      logic [FP_W-1:0] fp;
      int pos;
      int free_pos;
      int ix;
      a = '{ST_INVALID, NO_SLOT, '0, 1'b0};
      if (!parent_ok(ps, pk) || nm == 0 || nm >= name_limit || ek == ROOT_KIND) return a;
      packed_parent = {ps, pk};
      key = {nm, packed_parent};
      h = mix_key(({32'b0, nm} << 32 | HASH_W'(packed_parent)) ^ (HASH_W'(ek) * KIND_MUL));
      fp = h[31:0] ^ h[63:32];
      if (fp == 0) fp = 1;
      pos = h[IDX_W-1:0];
      free_pos = -1;
      for (int p = 0; p < INDEX_ENTRIES; p++) begin
         if (index_slot[pos] == NO_SLOT) begin
            free_pos = pos;
            break;
         end
         if (index_fp[pos] == fp && index_slot[pos] >= FIRST_LOCAL) begin
            ix = index_slot[pos] - 2;
            if (ix < live_records && stored_kind[ix] == ek && stored_key[ix] == key) begin
               a = '{ST_OK, index_slot[pos], ek, 1'b0};
               return a;
            end
         end
         pos = (pos + 1) % INDEX_ENTRIES;
      end
      if (!op) begin
         a.status = ST_NOT_FOUND;
         return a;
      end
      if (live_records >= MAX_RECORDS || free_pos < 0) begin
         a.status = ST_FULL;
         return a;
      end
      stored_key[live_records] = key;
      stored_kind[live_records] = ek;
      index_fp[free_pos] = fp;
      index_slot[free_pos] = SLOT_W'(live_records + 2);
      live_records++;
      a = '{ST_OK, SLOT_W'(live_records + 1), ek, 1'b1};
      return a;
   endfunction

   // Sends one request word, with a random gap before it now and then.
   // Valid stays high after acceptance until a gap or a drain lowers it.
   task automatic send_word(input logic op, input logic [SLOT_W-1:0] ps,
         input logic [KIND_W-1:0] pk, input logic [NAME_W-1:0] nm,
         input logic [KIND_W-1:0] ek);
      answer_type expected;
      if ($urandom_range(0, 5) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.kind <= op;
      req_bus.parent_slot <= ps;
      req_bus.parent_kind <= pk;
      req_bus.name_id <= nm;
      req_bus.entry_kind <= ek;
      expected = intern_lookup(op, ps, pk, nm, ek);
      pending_answers.insert(pending_answers.size(), expected);
      do @(posedge clock); while (!req_bus.ready);
   endtask

   // Waits until every answer is in, then lets the block settle.
   task automatic drain;
      req_bus.valid <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_name_limit(input logic [NAME_W-1:0] v);
      drain();
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      name_limit = v;
   endtask

   // Picks a parent: mostly root or a live slot with its kind.
   task automatic pick_parent(output logic [SLOT_W-1:0] ps, output logic [KIND_W-1:0] pk);
      int r;
      r = $urandom_range(0, 9);
      if (r < 3 || live_records == 0) begin
         ps = ROOT_SLOT;
         pk = ROOT_KIND;
      end else if (r < 9) begin
         ps = SLOT_W'($urandom_range(2, live_records + 1));
         pk = stored_kind[ps-2];
      end else begin
         ps = SLOT_W'($urandom);
         pk = KIND_W'($urandom);
      end
   endtask

   // Directed cases: invalid fields, root, misses, hits, extremes.
   task automatic test_directed;
      send_word(1'b1, ROOT_SLOT, ROOT_KIND, 32'd1, 4'd1);
      write_name_limit(32'd100);
      send_word(1'b0, ROOT_SLOT, ROOT_KIND, 32'd1, 4'd1);
      send_word(1'b1, ROOT_SLOT, ROOT_KIND, 32'd1, 4'd1);
      send_word(1'b1, ROOT_SLOT, ROOT_KIND, 32'd1, 4'd1);
      send_word(1'b0, ROOT_SLOT, ROOT_KIND, 32'd1, 4'd1);
      send_word(1'b1, ROOT_SLOT, ROOT_KIND, 32'd0, 4'd1);
      send_word(1'b1, ROOT_SLOT, ROOT_KIND, 32'd100, 4'd1);
      send_word(1'b1, ROOT_SLOT, ROOT_KIND, 32'd99, 4'd15);
      send_word(1'b1, ROOT_SLOT, ROOT_KIND, 32'd5, ROOT_KIND);
      send_word(1'b1, NO_SLOT, ROOT_KIND, 32'd5, 4'd2);
      send_word(1'b1, ROOT_SLOT, 4'd3, 32'd5, 4'd2);
      send_word(1'b1, 10'd2, 4'd1, 32'd7, 4'd4);
      send_word(1'b1, 10'd2, 4'd2, 32'd7, 4'd4);
      send_word(1'b0, 10'd4, 4'd4, 32'd7, 4'd4);
      send_word(1'b1, 10'd1023, 4'd15, 32'd7, 4'd4);
      write_name_limit(32'hFFFF_FFFF);
      send_word(1'b1, ROOT_SLOT, ROOT_KIND, 32'hFFFF_FFFE, 4'd15);
      send_word(1'b1, ROOT_SLOT, ROOT_KIND, 32'hFFFF_FFFF, 4'd15);
      send_word(1'b0, ROOT_SLOT, ROOT_KIND, 32'hFFFF_FFFE, 4'd15);
   endtask

   // Random requests; most reuse small names so hits, misses and inserts all occur.
   task automatic test_random(input int count);
      logic [SLOT_W-1:0] ps;
      logic [KIND_W-1:0] pk;
      logic [NAME_W-1:0] nm;
      for (int i = 0; i < count; i++) begin
         pick_parent(ps, pk);
         nm = ($urandom_range(0, 7) == 0) ? $urandom : NAME_W'($urandom_range(0, 40));
         send_word($urandom_range(0, 3) != 0, ps, pk, nm, KIND_W'($urandom));
         if (i == count / 2) drain();
      end
   endtask

   // Fills the record store to force the table-full answer.
   task automatic test_fill;
      while (live_records < MAX_RECORDS)
         send_word(1'b1, ROOT_SLOT, ROOT_KIND, $urandom_range(1, 32'hFFFF_FFFE),
                   KIND_W'($urandom_range(1, 15)));
      for (int i = 0; i < 20; i++) send_word(1'b1, ROOT_SLOT, ROOT_KIND,
                   $urandom_range(1, 32'hFFFF_FFFE), KIND_W'($urandom_range(1, 15)));
      test_random(60);
   endtask

   // Response checker with its own stall pattern.
   always @(posedge clock) begin
      answer_type e;
      rsp_stall_phase <= (rsp_stall_phase + 1) % 23;
      rsp_bus.ready <= (rsp_stall_phase < 8) ? 1'b1 : ($urandom_range(0, 2) != 0);
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_answers.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("Unexpected response word");
         end else begin
            e = pending_answers.pop_front();
            if (rsp_bus.status !== e.status || rsp_bus.result_slot !== e.slot ||
                rsp_bus.result_kind !== e.kind || rsp_bus.is_new !== e.is_new) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("Mismatch: expected %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                           e.status, e.slot, e.kind, e.is_new, rsp_bus.status,
                           rsp_bus.result_slot, rsp_bus.result_kind, rsp_bus.is_new);
            end
         end
      end
   end

   // Watchdog on cycles with no accepted word.
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      for (int i = 0; i < INDEX_ENTRIES; i++) index_slot[i] = NO_SLOT;
      live_records = 0;
      name_limit = 32'd1;
      req_bus.valid = 1'b0;
      req_bus.kind = 1'b0;
      req_bus.parent_slot = '0;
      req_bus.parent_kind = '0;
      req_bus.name_id = '0;
      req_bus.entry_kind = '0;
      rsp_bus.ready = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      write_name_limit(32'd41);
      test_random(1300);
      write_name_limit(32'hFFFF_FFFF);
      test_fill();
      write_name_limit(32'd1);
      test_random(40);
      drain();
      if (mismatch_count == 0 && pending_answers.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
